[rtl/sha1_pkg.sv]
`default_nettype none

package sha1_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] chain_t;

  localparam logic [1:0] ActAbsorb = 2'd0;
  localparam logic [1:0] ActFinish = 2'd1;
  localparam logic [1:0] ActRaw    = 2'd2;

  localparam word_t Iv0 = 32'h67452301;
  localparam word_t Iv1 = 32'hEFCDAB89;
  localparam word_t Iv2 = 32'h98BADCFE;
  localparam word_t Iv3 = 32'h10325476;
  localparam word_t Iv4 = 32'hC3D2E1F0;

  localparam word_t K0 = 32'h5a827999;
  localparam word_t K1 = 32'h6ed9eba1;
  localparam word_t K2 = 32'h8f1bbcdc;
  localparam word_t K3 = 32'hca62c1d6;

  localparam logic [7:0] PadMark = 8'h80;

  localparam logic [6:0] Round20   = 7'd20;
  localparam logic [6:0] Round40   = 7'd40;
  localparam logic [6:0] Round60   = 7'd60;
  localparam logic [6:0] RoundLast = 7'd79;

  localparam logic [5:0] FillLenPos = 6'd55;
  localparam logic [5:0] FillLast   = 6'd63;
  localparam logic [2:0] WordLast   = 3'd4;

  typedef struct packed {
    logic load;
    logic step;
  } core_ctrl_t;

  typedef struct packed {
    logic       shift_byte;
    logic       step;
    logic [7:0] data;
  } sched_ctrl_t;

endpackage

`default_nettype wire

[rtl/sha1_in_if.sv]
`default_nettype none

interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] msg_byte;

  modport source (output valid, output action, output msg_byte, input ready);
  modport sink (input valid, input action, input msg_byte, output ready);
endinterface

`default_nettype wire

[rtl/sha1_out_if.sv]
`default_nettype none

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink (input valid, input digest_word, input word_index,
                input last_word, output ready);
endinterface

`default_nettype wire

[rtl/sha1_sched.sv]
`default_nettype none

module sha1_sched (
  input  wire                   clk_i,
  input  sha1_pkg::sched_ctrl_t ctrl_i,
  output sha1_pkg::word_t       w_o
);

  sha1_pkg::word_t w_q [16];
  sha1_pkg::word_t w_d [16];
  sha1_pkg::word_t mix;

  // window holds w[t..t+15], w[t] at the low end
  assign mix = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      w_d[i] = w_q[i];
    end
    if (ctrl_i.shift_byte) begin
      // bytes enter at the tail, first byte ends up in the msb of word 0
      for (int i = 0; i < 15; i++) begin
        w_d[i] = {w_q[i][23:0], w_q[i+1][31:24]};
      end
      w_d[15] = {w_q[15][23:0], ctrl_i.data};
    end else if (ctrl_i.step) begin
      for (int i = 0; i < 15; i++) begin
        w_d[i] = w_q[i+1];
      end
      w_d[15] = {mix[30:0], mix[31]};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 16; i++) begin
      w_q[i] <= w_d[i];
    end
  end

  assign w_o = w_q[0];

endmodule

`default_nettype wire

[rtl/sha1_round.sv]
`default_nettype none

module sha1_round (
  input  wire                  clk_i,
  input  sha1_pkg::core_ctrl_t ctrl_i,
  input  wire [6:0]            round_i,
  input  sha1_pkg::word_t      w_i,
  input  sha1_pkg::chain_t     chain_i,
  output sha1_pkg::chain_t     work_o
);

  sha1_pkg::chain_t work_q;
  sha1_pkg::chain_t work_d;
  sha1_pkg::word_t  a, b, c, d, e;
  sha1_pkg::word_t  f, k, t;

  assign a = work_q[0];
  assign b = work_q[1];
  assign c = work_q[2];
  assign d = work_q[3];
  assign e = work_q[4];

  always_comb begin
    priority if (round_i < sha1_pkg::Round20) begin
      f = (b & c) | (~b & d);
      k = sha1_pkg::K0;
    end else if (round_i < sha1_pkg::Round40) begin
      f = b ^ c ^ d;
      k = sha1_pkg::K1;
    end else if (round_i < sha1_pkg::Round60) begin
      f = (b & c) | (b & d) | (c & d);
      k = sha1_pkg::K2;
    end else begin
      f = b ^ c ^ d;
      k = sha1_pkg::K3;
    end
  end

  assign t = {a[26:0], a[31:27]} + f + e + k + w_i;

  always_comb begin
    work_d = work_q;
    if (ctrl_i.load) begin
      work_d = chain_i;
    end else if (ctrl_i.step) begin
      work_d[0] = t;
      work_d[1] = a;
      work_d[2] = {b[1:0], b[31:2]};
      work_d[3] = c;
      work_d[4] = d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign work_o = work_q;

endmodule

`default_nettype wire

[rtl/sha1_hash_engine_top.sv]
`default_nettype none

// SHA-1 engine, one message byte per input beat. Every 64th absorbed byte
// also starts a compression that holds ready low through 80 rounds on the
// single shared round unit and a fold of the working words into the
// chaining value. A padded finish with p bytes buffered shifts in 64 - p
// padding bytes one per cycle and then compresses; when p is 56 or more a
// second block of 64 padding bytes and another compression follows.
// Both finishes then hand out five digest beats, h0 first, and accept no new
// input until the fifth beat is taken. Action code 3 is absorbed as a no-op.
module sha1_hash_engine_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  sha1_in_if.sink     msg_i,
  sha1_out_if.source  dig_o
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StPad   = 5'b00010,
    StRound = 5'b00100,
    StFold  = 5'b01000,
    StEmit  = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [5:0]         fill_q, fill_d;
  logic [60:0]        total_q, total_d;
  logic [63:0]        len_q, len_d;
  logic               mark_q, mark_d;
  logic               len_ph_q, len_ph_d;
  logic               pad_q, pad_d;
  logic               last_q, last_d;
  logic [6:0]         round_q, round_d;
  logic [2:0]         idx_q, idx_d;
  sha1_pkg::chain_t   chain_q, chain_d;

  sha1_pkg::core_ctrl_t  core_ctrl;
  sha1_pkg::sched_ctrl_t sched_ctrl;
  sha1_pkg::chain_t      work;
  sha1_pkg::word_t       w_cur;
  logic [7:0]            pad_byte;
  sha1_pkg::chain_t      chain_iv;

  assign chain_iv = {sha1_pkg::Iv4, sha1_pkg::Iv3, sha1_pkg::Iv2,
                     sha1_pkg::Iv1, sha1_pkg::Iv0};

  sha1_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .w_o    (w_cur)
  );

  sha1_round u_round (
    .clk_i   (clk_i),
    .ctrl_i  (core_ctrl),
    .round_i (round_q),
    .w_i     (w_cur),
    .chain_i (chain_q),
    .work_o  (work)
  );

  assign pad_byte = len_ph_q ? len_q[63:56] : (mark_q ? sha1_pkg::PadMark : 8'h00);

  assign msg_i.ready       = (state_q == StIdle);
  assign dig_o.valid       = (state_q == StEmit);
  assign dig_o.digest_word = chain_q[idx_q];
  assign dig_o.word_index  = idx_q;
  assign dig_o.last_word   = (idx_q == sha1_pkg::WordLast);

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    total_d    = total_q;
    len_d      = len_q;
    mark_d     = mark_q;
    len_ph_d   = len_ph_q;
    pad_d      = pad_q;
    last_d     = last_q;
    round_d    = round_q;
    idx_d      = idx_q;
    chain_d    = chain_q;
    core_ctrl  = '0;
    sched_ctrl = '0;

    unique case (state_q)
      StIdle: begin
        if (msg_i.valid) begin
          unique case (msg_i.action)
            sha1_pkg::ActAbsorb: begin
              sched_ctrl.shift_byte = 1'b1;
              sched_ctrl.data       = msg_i.msg_byte;
              total_d               = total_q + 61'd1;
              fill_d                = fill_q + 6'd1;
              if (fill_q == sha1_pkg::FillLast) begin
                core_ctrl.load = 1'b1;
                round_d        = '0;
                state_d        = StRound;
              end
            end
            sha1_pkg::ActFinish: begin
              len_d    = {total_q, 3'b000};
              mark_d   = 1'b1;
              len_ph_d = 1'b0;
              pad_d    = 1'b1;
              last_d   = 1'b0;
              state_d  = StPad;
            end
            sha1_pkg::ActRaw: begin
              pad_d   = 1'b0;
              idx_d   = '0;
              state_d = StEmit;
            end
            default: begin
            end
          endcase
        end
      end
      StPad: begin
        sched_ctrl.shift_byte = 1'b1;
        sched_ctrl.data       = pad_byte;
        mark_d                = 1'b0;
        fill_d                = fill_q + 6'd1;
        if (len_ph_q) begin
          len_d = {len_q[55:0], 8'h00};
        end
        // length bytes take the last eight slots of a block
        if (fill_q == sha1_pkg::FillLenPos) begin
          len_ph_d = 1'b1;
        end
        if (fill_q == sha1_pkg::FillLast) begin
          core_ctrl.load = 1'b1;
          round_d        = '0;
          state_d        = StRound;
          if (len_ph_q) begin
            last_d   = 1'b1;
            len_ph_d = 1'b0;
          end
        end
      end
      StRound: begin
        core_ctrl.step  = 1'b1;
        sched_ctrl.step = 1'b1;
        round_d         = round_q + 7'd1;
        if (round_q == sha1_pkg::RoundLast) begin
          state_d = StFold;
        end
      end
      StFold: begin
        for (int i = 0; i < 5; i++) begin
          chain_d[i] = chain_q[i] + work[i];
        end
        if (pad_q && !last_q) begin
          state_d = StPad;
        end else if (pad_q) begin
          idx_d   = '0;
          state_d = StEmit;
        end else begin
          state_d = StIdle;
        end
      end
      StEmit: begin
        if (dig_o.ready) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == sha1_pkg::WordLast) begin
            state_d = StIdle;
            if (pad_q) begin
              chain_d = chain_iv;
              total_d = '0;
              fill_d  = '0;
              pad_d   = 1'b0;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      fill_q   <= '0;
      total_q  <= '0;
      mark_q   <= 1'b0;
      len_ph_q <= 1'b0;
      pad_q    <= 1'b0;
      last_q   <= 1'b0;
      round_q  <= '0;
      idx_q    <= '0;
      chain_q  <= chain_iv;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      total_q  <= total_d;
      mark_q   <= mark_d;
      len_ph_q <= len_ph_d;
      pad_q    <= pad_d;
      last_q   <= last_d;
      round_q  <= round_d;
      idx_q    <= idx_d;
      chain_q  <= chain_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
  end

`ifndef SYNTH
  a_no_ready_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(msg_i.ready && dig_o.valid))
    else $error("input ready while digest beats pending");

  a_round_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRound) |-> (round_q <= sha1_pkg::RoundLast))
    else $error("round counter ran past the last round");

  a_full_block_compresses: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (msg_i.valid && msg_i.ready && (msg_i.action == sha1_pkg::ActAbsorb) &&
     (fill_q == sha1_pkg::FillLast)) |=> (state_q == StRound && fill_q == 6'd0))
    else $error("full block did not start a compression");

  a_last_beat_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dig_o.valid && dig_o.ready && dig_o.last_word) |=> msg_i.ready)
    else $error("input not ready after the final digest beat");

  a_padded_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dig_o.valid && dig_o.ready && dig_o.last_word && pad_q) |=>
    (total_q == 61'd0 && chain_q[0] == sha1_pkg::Iv0))
    else $error("padded finish did not restore the initial state");
`endif

endmodule

`default_nettype wire
